FILE: design/lcs_pkg.sv
// ----------------------------------------------------------------------------
// lcs_pkg: shared types and codes of the line diff block
// Opcodes, edit kinds, controller states and the per-cell direction record.
// ----------------------------------------------------------------------------
package lcs_pkg;

	localparam int OPCODE_W = 2;
	localparam int KIND_W   = 2;
	localparam int TOKEN_W  = 32;
	localparam int MASK_W   = 2;

	typedef enum logic [OPCODE_W-1:0] {
		OP_APPEND_A = 2'd0,
		OP_APPEND_B = 2'd1,
		OP_RUN      = 2'd2,
		OP_NONE     = 2'd3
	} lcs_op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_KEPT    = 2'd0,
		KIND_ADDED   = 2'd1,
		KIND_REMOVED = 2'd2
	} lcs_kind_t;

	localparam int MASK_ADDED_BIT   = 0;
	localparam int MASK_REMOVED_BIT = 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_TRACE,
		ST_RD,
		ST_CHK,
		ST_OUT
	} lcs_state_t;

	// decision recorded by a cell for one table entry
	typedef struct packed {
		logic match;
		logic up_gt;
	} lcs_dir_t;

endpackage

FILE: design/lcs_in_if.sv
// ----------------------------------------------------------------------------
// lcs_in_if: input request channel
// Carries one opcode and one line token per request.
// ----------------------------------------------------------------------------
interface lcs_in_if import lcs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [OPCODE_W-1:0] opcode;
	logic [TOKEN_W-1:0]  line_token;

	modport source (output valid, opcode, line_token, input ready);
	modport sink (input valid, opcode, line_token, output ready);
endinterface

FILE: design/lcs_out_if.sv
// ----------------------------------------------------------------------------
// lcs_out_if: edit script channel
// Carries one edit of the script per request.
// ----------------------------------------------------------------------------
interface lcs_out_if import lcs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [KIND_W-1:0]  edit_kind;
	logic [TOKEN_W-1:0] out_token;
	logic               last;
	logic               overflowed;

	modport source (output valid, edit_kind, out_token, last, overflowed, input ready);
	modport sink (input valid, edit_kind, out_token, last, overflowed, output ready);
endinterface

FILE: design/lcs_cfg_if.sv
// ----------------------------------------------------------------------------
// lcs_cfg_if: configuration write channel
// Carries the show mask register write data.
// ----------------------------------------------------------------------------
interface lcs_cfg_if import lcs_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [MASK_W-1:0] show_mask;

	modport source (output valid, show_mask, input ready);
	modport sink (input valid, show_mask, output ready);
endinterface

FILE: design/lcs_cell.sv
// ----------------------------------------------------------------------------
// lcs_cell: one column of the score table
// Holds one token of the second sequence and the running score of its column;
// scores one row per request from its left neighbor and passes the row on.
// ----------------------------------------------------------------------------
module lcs_cell import lcs_pkg::*; #(
	parameter int MAX_LINES = 32,
	parameter int TW        = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           clear,
	input  logic                           b_we,
	input  logic [TW-1:0]                  b_data,
	input  logic                           val_in,
	input  logic [TW-1:0]                  tok_in,
	input  logic [$clog2(MAX_LINES)-1:0]   row_in,
	input  logic [$clog2(MAX_LINES+1)-1:0] left_score,
	input  logic [$clog2(MAX_LINES+1)-1:0] left_prev,
	output logic                           val_out,
	output logic [TW-1:0]                  tok_out,
	output logic [$clog2(MAX_LINES)-1:0]   row_out,
	output logic [$clog2(MAX_LINES+1)-1:0] score_out,
	output logic [$clog2(MAX_LINES+1)-1:0] prev_out,
	input  logic [$clog2(MAX_LINES)-1:0]   rd_row,
	output lcs_dir_t                       rd_dir,
	output logic [TW-1:0]                  b_out
);

	localparam int RW = $clog2(MAX_LINES);
	localparam int SW = $clog2(MAX_LINES+1);

	logic          val_q;
	logic [TW-1:0] tok_q;
	logic [RW-1:0] row_q;
	logic [SW-1:0] score_q;
	logic [SW-1:0] prev_q;
	logic [TW-1:0] b_q;
	lcs_dir_t      dir_q [MAX_LINES];

	logic          match;
	logic          up_gt;
	logic [SW-1:0] v;

	always_comb begin
		match = (tok_in == b_q);
		up_gt = (score_q > left_score);
		if (match) begin
			v = left_prev + SW'(1);
		end else if (up_gt) begin
			v = score_q;
		end else begin
			v = left_score;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q   <= 1'b0;
			score_q <= '0;
			prev_q  <= '0;
		end else if (clear) begin
			val_q   <= 1'b0;
			score_q <= '0;
			prev_q  <= '0;
		end else begin
			val_q <= val_in;
			if (val_in) begin
				score_q <= v;
				prev_q  <= score_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		tok_q <= tok_in;
		row_q <= row_in;
		if (b_we) begin
			b_q <= b_data;
		end
		if (val_in) begin
			dir_q[row_in] <= '{match: match, up_gt: up_gt};
		end
	end

	assign val_out   = val_q;
	assign tok_out   = tok_q;
	assign row_out   = row_q;
	assign score_out = score_q;
	assign prev_out  = prev_q;
	assign rd_dir    = dir_q[rd_row];
	assign b_out     = b_q;

endmodule

FILE: design/lcs_line_diff.sv
// ----------------------------------------------------------------------------
// lcs_line_diff: line diff by longest common subsequence over line tokens
// Loads two token sequences, scores them in a row of cells and emits the
// edit script in forward order.
// ----------------------------------------------------------------------------
// Load requests (opcode 0 or 1) are taken one per cycle and append a token to
// the first or second sequence; tokens past MAX_LINES are dropped and raise
// the overflowed flag of the next run. A run request (opcode 2) blocks the
// input until the whole script has been delivered. The run scores the table
// in a row of MAX_LINES cells, one per token of the second sequence: the
// first sequence streams through the row one token per cycle. The traceback
// walks one table step per cycle through the direction bits that each cell
// recorded. The script is then read back from a 2*MAX_LINES entry edit
// buffer: each edit is read, checked against the show mask and, if shown,
// held on the output until its request is taken. Opcode 3 is ignored. The
// show mask may be written only while no run is in progress.
// ----------------------------------------------------------------------------
module lcs_line_diff import lcs_pkg::*; #(
	parameter int MAX_LINES  = 32,
	parameter int TOKEN_BITS = 32
) (
	input  logic   clk,
	input  logic   arst_n,
	lcs_in_if.sink   item_in,
	lcs_out_if.source edit_out,
	lcs_cfg_if.sink  cfg
);

	localparam int TW = (TOKEN_BITS < TOKEN_W) ? TOKEN_BITS : TOKEN_W;
	localparam int RW = $clog2(MAX_LINES);
	localparam int CW = $clog2(MAX_LINES+1);
	localparam int SW = CW;
	localparam int PW = $clog2(2*MAX_LINES+1);
	localparam int EW = $clog2(2*MAX_LINES);
	localparam int FW = $clog2(2*MAX_LINES+2);
	localparam int BW = KIND_W + TW;

	// state and control
	lcs_state_t state_q, state_d;
	logic [MASK_W-1:0] mask_q;
	logic [CW-1:0] cnt_a_q, cnt_b_q;
	logic          ovf_q;
	logic [FW-1:0] fill_q;
	logic [CW-1:0] ti_q, tj_q;
	logic [PW-1:0] pos_q, n_q, rd_q;
	logic [PW-1:0] last_idx_q;
	logic          last_found_q;

	// stores
	logic [TW-1:0] first_mem [MAX_LINES];
	logic [BW-1:0] edit_buf [2*MAX_LINES];
	logic [BW-1:0] rd_data_q;

	// output register
	logic [KIND_W-1:0] o_kind_q;
	logic [TW-1:0]     o_tok_q;
	logic              o_last_q;

	// feed into the cell row
	logic          feed_val_s1;
	logic [TW-1:0] feed_tok_s1;
	logic [RW-1:0] feed_row_s1;

	// cell row wiring
	logic          c_val   [MAX_LINES+1];
	logic [TW-1:0] c_tok   [MAX_LINES+1];
	logic [RW-1:0] c_row   [MAX_LINES+1];
	logic [SW-1:0] c_score [MAX_LINES+1];
	logic [SW-1:0] c_prev  [MAX_LINES+1];
	lcs_dir_t      c_dir   [MAX_LINES];
	logic [TW-1:0] c_b     [MAX_LINES];

	// decoded controls
	logic in_acc, run_start, cell_clear, fill_done, trace_end, rd_end;
	logic load_a, load_b;
	logic [TW-1:0] in_tok;

	// traceback step
	logic [CW-1:0] im1_full, jm1_full;
	logic [RW-1:0] im1, jm1;
	lcs_dir_t      tb_dir;
	logic          tb_match, tb_remove, tb_show;
	lcs_kind_t     tb_kind;
	logic [TW-1:0] tb_tok;
	logic [PW-1:0] pos_m1;

	// read-back check
	lcs_kind_t rd_kind;
	logic      rd_show;

	assign in_tok = item_in.line_token[TW-1:0];
	assign in_acc = item_in.valid && item_in.ready;
	assign load_a = in_acc && (item_in.opcode == OP_APPEND_A);
	assign load_b = in_acc && (item_in.opcode == OP_APPEND_B);
	assign run_start = in_acc && (item_in.opcode == OP_RUN);
	assign cfg.ready = 1'b1;

	assign fill_done = (fill_q == FW'(cnt_a_q) + FW'(MAX_LINES + 1));
	assign trace_end = (ti_q == '0) && (tj_q == '0);
	assign rd_end    = (rd_q == n_q);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (run_start) state_d = ST_FILL;
			ST_FILL:  if (fill_done) state_d = ST_TRACE;
			ST_TRACE: if (trace_end) state_d = ST_RD;
			ST_RD:    state_d = rd_end ? ST_IDLE : ST_CHK;
			ST_CHK:   state_d = rd_show ? ST_OUT : ST_RD;
			ST_OUT:   if (edit_out.ready) state_d = ST_RD;
			default:  state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		item_in.ready  = 1'b0;
		edit_out.valid = 1'b0;
		cell_clear     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				item_in.ready = 1'b1;
				cell_clear    = run_start;
			end
			ST_OUT:  edit_out.valid = 1'b1;
			default: ;
		endcase
	end

	assign edit_out.edit_kind  = o_kind_q;
	assign edit_out.out_token  = TOKEN_W'(o_tok_q);
	assign edit_out.last       = o_last_q;
	assign edit_out.overflowed = ovf_q;

	// traceback decision at (ti, tj)
	always_comb begin
		im1_full  = ti_q - CW'(1);
		jm1_full  = tj_q - CW'(1);
		im1       = im1_full[RW-1:0];
		jm1       = jm1_full[RW-1:0];
		tb_dir    = c_dir[jm1];
		tb_match  = (ti_q != '0) && (tj_q != '0) && tb_dir.match;
		tb_remove = !tb_match && (ti_q != '0) && ((tj_q == '0) || tb_dir.up_gt);
		if (tb_match) begin
			tb_kind = KIND_KEPT;
			tb_tok  = first_mem[im1];
		end else if (tb_remove) begin
			tb_kind = KIND_REMOVED;
			tb_tok  = first_mem[im1];
		end else begin
			tb_kind = KIND_ADDED;
			tb_tok  = c_b[jm1];
		end
		unique case (tb_kind)
			KIND_KEPT:    tb_show = 1'b1;
			KIND_ADDED:   tb_show = mask_q[MASK_ADDED_BIT];
			KIND_REMOVED: tb_show = mask_q[MASK_REMOVED_BIT];
			default:      tb_show = 1'b0;
		endcase
		pos_m1 = pos_q - PW'(1);
	end

	always_comb begin
		rd_kind = lcs_kind_t'(rd_data_q[BW-1 -: KIND_W]);
		unique case (rd_kind)
			KIND_KEPT:    rd_show = 1'b1;
			KIND_ADDED:   rd_show = mask_q[MASK_ADDED_BIT];
			KIND_REMOVED: rd_show = mask_q[MASK_REMOVED_BIT];
			default:      rd_show = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mask_q       <= MASK_W'(3);
			cnt_a_q      <= '0;
			cnt_b_q      <= '0;
			ovf_q        <= 1'b0;
			fill_q       <= '0;
			ti_q         <= '0;
			tj_q         <= '0;
			pos_q        <= '0;
			n_q          <= '0;
			rd_q         <= '0;
			last_idx_q   <= '0;
			last_found_q <= 1'b0;
			feed_val_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				mask_q <= cfg.show_mask;
			end
			// append or flag a dropped token
			if (load_a) begin
				if (cnt_a_q < CW'(MAX_LINES)) cnt_a_q <= cnt_a_q + CW'(1);
				else ovf_q <= 1'b1;
			end
			if (load_b) begin
				if (cnt_b_q < CW'(MAX_LINES)) cnt_b_q <= cnt_b_q + CW'(1);
				else ovf_q <= 1'b1;
			end
			feed_val_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (run_start) begin
						fill_q       <= '0;
						ti_q         <= cnt_a_q;
						tj_q         <= cnt_b_q;
						pos_q        <= PW'(cnt_a_q) + PW'(cnt_b_q);
						n_q          <= PW'(cnt_a_q) + PW'(cnt_b_q);
						last_found_q <= 1'b0;
					end
				end
				ST_FILL: begin
					fill_q      <= fill_q + FW'(1);
					feed_val_s1 <= (fill_q < FW'(cnt_a_q));
				end
				ST_TRACE: begin
					if (trace_end) begin
						rd_q <= pos_q;
					end else begin
						pos_q <= pos_m1;
						if (tb_match || tb_remove) ti_q <= im1_full;
						if (!tb_remove) tj_q <= jm1_full;
						// the first shown edit found backward is the last one forward
						if (tb_show && !last_found_q) begin
							last_idx_q   <= pos_m1;
							last_found_q <= 1'b1;
						end
					end
				end
				ST_RD: begin
					if (rd_end) begin
						cnt_a_q <= '0;
						cnt_b_q <= '0;
						ovf_q   <= 1'b0;
					end
				end
				ST_CHK: begin
					if (!rd_show) rd_q <= rd_q + PW'(1);
				end
				ST_OUT: begin
					if (edit_out.ready) rd_q <= rd_q + PW'(1);
				end
				default: ;
			endcase
		end
	end

	// payload registers and stores
	always_ff @(posedge clk) begin
		if (load_a && (cnt_a_q < CW'(MAX_LINES))) begin
			first_mem[cnt_a_q[RW-1:0]] <= in_tok;
		end
		feed_tok_s1 <= first_mem[fill_q[RW-1:0]];
		feed_row_s1 <= fill_q[RW-1:0];
		if (state_q == ST_TRACE && !trace_end) begin
			edit_buf[pos_m1[EW-1:0]] <= {tb_kind, tb_tok};
		end
		if (state_q == ST_RD) begin
			rd_data_q <= edit_buf[rd_q[EW-1:0]];
		end
		if (state_q == ST_CHK) begin
			o_kind_q <= rd_data_q[BW-1 -: KIND_W];
			o_tok_q  <= rd_data_q[TW-1:0];
			o_last_q <= (rd_q == last_idx_q);
		end
	end

	// row of cells; the left border scores as zero
	assign c_val[0]   = feed_val_s1;
	assign c_tok[0]   = feed_tok_s1;
	assign c_row[0]   = feed_row_s1;
	assign c_score[0] = '0;
	assign c_prev[0]  = '0;

	for (genvar k = 0; k < MAX_LINES; k++) begin : g_cell
		logic b_we;
		assign b_we = load_b && (cnt_b_q < CW'(MAX_LINES)) && (cnt_b_q[RW-1:0] == RW'(k));

		lcs_cell #(
			.MAX_LINES(MAX_LINES),
			.TW       (TW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.clear     (cell_clear),
			.b_we      (b_we),
			.b_data    (in_tok),
			.val_in    (c_val[k]),
			.tok_in    (c_tok[k]),
			.row_in    (c_row[k]),
			.left_score(c_score[k]),
			.left_prev (c_prev[k]),
			.val_out   (c_val[k+1]),
			.tok_out   (c_tok[k+1]),
			.row_out   (c_row[k+1]),
			.score_out (c_score[k+1]),
			.prev_out  (c_prev[k+1]),
			.rd_row    (im1),
			.rd_dir    (c_dir[k]),
			.b_out     (c_b[k])
		);
	end

	// a taken edit always returns to the read-back step
	a_out_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && edit_out.ready) |=> state_q == ST_RD)
		else $error("edit request taken without advancing");

	// the buffer position never falls below what the walk still needs
	a_pos_room: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TRACE) |-> (pos_q >= PW'(ti_q) + PW'(tj_q)))
		else $error("traceback ran past the edit buffer");

	// the end of a run clears both sequences and the overflow flag
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD && rd_end) |=> (cnt_a_q == '0 && cnt_b_q == '0 && !ovf_q))
		else $error("sequences not cleared after run");

	// counts stay within capacity
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_a_q <= CW'(MAX_LINES)) && (cnt_b_q <= CW'(MAX_LINES)))
		else $error("sequence count beyond capacity");

endmodule

FILE: dv/tb_lcs_ifs.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_lcs_ifs: testbench-side view of the line diff channels
// Bundles the three channel interfaces for the bench top.
// ----------------------------------------------------------------------------
interface tb_lcs_chan_bundle;
	lcs_in_if  item_ch ();
	lcs_out_if edit_ch ();
	lcs_cfg_if cfg_ch ();
endinterface

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: line diff bench
// Loads token sequences, runs diffs under every show mask and checks each edit
// of the script against an in-bench LCS predictor, with random idling on both
// sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module tb_top;
	import lcs_pkg::*;

	localparam int LINES   = 32;
	localparam int LIMIT   = 400000;

	typedef struct packed {
		lcs_kind_t        kind;
		logic [TOKEN_W-1:0] tok;
		logic             last;
		logic             ovf;
	} edit_t;

	// Scoreboard: tracks sequences and mask, queues predicted edits
	class diff_scoreboard;
		logic [TOKEN_W-1:0] seq_a[LINES];
		logic [TOKEN_W-1:0] seq_b[LINES];
		int   len_a, len_b;
		bit   dropped;
		logic [MASK_W-1:0] mask;
		edit_t pending[$];
		int   errors;

		function void clear_all();
			len_a = 0; len_b = 0; dropped = 0; mask = 2'd3;
			pending.delete(); errors = 0;
		endfunction

		// Apply one accepted request to the predictor state
		function void note_request(lcs_op_t op, logic [TOKEN_W-1:0] tok);
			int sc[LINES+1][LINES+1];
			edit_t script[$];
			edit_t e;
			int i, j;
			case (op)
				OP_APPEND_A: begin
					if (len_a < LINES) seq_a[len_a++] = tok; else dropped = 1;
				end
				OP_APPEND_B: begin
					if (len_b < LINES) seq_b[len_b++] = tok; else dropped = 1;
				end
				OP_RUN: begin
					for (i = 0; i <= len_a; i++)
						for (j = 0; j <= len_b; j++)
							if (i == 0 || j == 0) sc[i][j] = 0;
							else if (seq_a[i-1] == seq_b[j-1]) sc[i][j] = sc[i-1][j-1] + 1;
							else sc[i][j] = (sc[i-1][j] >= sc[i][j-1]) ? sc[i-1][j] : sc[i][j-1];
					// walk back from the corner; build script front-first
					i = len_a; j = len_b;
					while (i > 0 || j > 0) begin
						e.last = 0; e.ovf = dropped;
						if (i > 0 && j > 0 && seq_a[i-1] == seq_b[j-1]) begin
							e.kind = KIND_KEPT; e.tok = seq_a[i-1]; i--; j--;
						end else if (i > 0 && (j == 0 || sc[i-1][j] > sc[i][j-1])) begin
							e.kind = KIND_REMOVED; e.tok = seq_a[i-1]; i--;
						end else begin
							e.kind = KIND_ADDED; e.tok = seq_b[j-1]; j--;
						end
						if (e.kind == KIND_KEPT ||
						    (e.kind == KIND_ADDED && mask[MASK_ADDED_BIT]) ||
						    (e.kind == KIND_REMOVED && mask[MASK_REMOVED_BIT]))
							script.push_front(e);
					end
					if (script.size() > 0) script[script.size()-1].last = 1;
					foreach (script[k]) pending.push_back(script[k]);
					len_a = 0; len_b = 0; dropped = 0;
				end
				default: ;
			endcase
		endfunction

		function void check_edit(edit_t got);
			edit_t exp;
			if (pending.size() == 0) begin
				$error("unexpected edit kind=%0d token=%h", got.kind, got.tok);
				errors++;
				return;
			end
			exp = pending.pop_front();
			if (got.kind !== exp.kind) begin
				$error("edit_kind exp %0d got %0d", exp.kind, got.kind); errors++;
			end
			if (got.tok !== exp.tok) begin
				$error("out_token exp %h got %h", exp.tok, got.tok); errors++;
			end
			if (got.last !== exp.last) begin
				$error("last exp %0d got %0d", exp.last, got.last); errors++;
			end
			if (got.ovf !== exp.ovf) begin
				$error("overflowed exp %0d got %0d", exp.ovf, got.ovf); errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	diff_scoreboard sb;
	int   cycle_cnt = 0;
	int   holdoff_cycles = 0;  // long output hold-off, counted by the sink
	bit   stim_done = 0;

	tb_lcs_chan_bundle ch ();

	lcs_line_diff i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.item_in  (ch.item_ch),
		.edit_out (ch.edit_ch),
		.cfg      (ch.cfg_ch)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	initial begin
		ch.item_ch.valid = 0;
		ch.item_ch.opcode = OP_NONE;
		ch.item_ch.line_token = '0;
		ch.edit_ch.ready = 0;
		ch.cfg_ch.valid = 0;
		ch.cfg_ch.show_mask = '0;
	end

	// Timeout watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt > LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Output sink: random stalls, plus a long hold-off when requested
	initial begin
		int w;
		edit_t got;
		@(posedge arst_n);
		forever begin
			if (holdoff_cycles > 0) begin
				ch.edit_ch.ready <= 0;
				repeat (holdoff_cycles) @(posedge clk);
				holdoff_cycles = 0;
			end
			// about one edit in four, chosen at random: no stall before it
			w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (w > 0) begin
				ch.edit_ch.ready <= 0;
				repeat (w) @(posedge clk);
			end
			ch.edit_ch.ready <= 1;
			do @(posedge clk); while (!ch.edit_ch.valid);
			got.kind = lcs_kind_t'(ch.edit_ch.edit_kind);
			got.tok  = ch.edit_ch.out_token;
			got.last = ch.edit_ch.last;
			got.ovf  = ch.edit_ch.overflowed;
			sb.check_edit(got);
		end
	end

	bit burst_mode = 0;  // sender offers back to back

	// Send one request; hold it until taken
	task automatic send_request(lcs_op_t op, logic [TOKEN_W-1:0] tok);
		int w;
		w = burst_mode ? 0 : $urandom_range(0, 7);
		if (w > 0) begin
			ch.item_ch.valid <= 0;
			repeat (w) @(posedge clk);
		end
		ch.item_ch.valid <= 1;
		ch.item_ch.opcode <= op;
		ch.item_ch.line_token <= tok;
		do @(posedge clk); while (!ch.item_ch.ready);
		sb.note_request(op, tok);
	endtask

	task automatic end_burst();
		ch.item_ch.valid <= 0;
		@(posedge clk);
	endtask

	// Drain expected edits, then let a trailing run settle
	task automatic drain();
		end_burst();
		while (sb.pending.size() > 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_mask(logic [MASK_W-1:0] m);
		ch.cfg_ch.valid <= 1;
		ch.cfg_ch.show_mask <= m;
		do @(posedge clk); while (!ch.cfg_ch.ready);
		ch.cfg_ch.valid <= 0;
		sb.mask = m;
	endtask

	// Draw a token from a small pool so lines repeat and match often
	function automatic logic [TOKEN_W-1:0] pick_token(int pool);
		if ($urandom_range(0, 9) == 0) return $urandom();
		return $urandom_range(0, pool);
	endfunction

	task automatic random_diff(int max_len);
		int na, nb, pool, k;
		na = $urandom_range(0, max_len);
		nb = $urandom_range(0, max_len);
		pool = $urandom_range(1, 6);
		for (k = 0; k < na + nb; k++)
			// interleave appends to both sequences
			if (k < na && ($urandom_range(0, 1) || k >= nb + na))
				send_request(OP_APPEND_A, pick_token(pool));
			else
				send_request(OP_APPEND_B, pick_token(pool));
		if ($urandom_range(0, 15) == 0) send_request(OP_NONE, $urandom());
		send_request(OP_RUN, $urandom());
	endtask

	initial begin
		int k, n;
		sb = new();
		sb.clear_all();
		repeat (2) @(posedge clk);
		arst_n = 1;
		@(posedge clk);

		// Directed: identical sequences, extreme tokens, ignored opcode
		send_request(OP_APPEND_A, 32'hFFFF_FFFF);
		send_request(OP_APPEND_B, 32'hFFFF_FFFF);
		send_request(OP_APPEND_A, 32'h0000_0000);
		send_request(OP_APPEND_B, 32'h0000_0000);
		send_request(OP_NONE, 32'h5A5A_A5A5);
		send_request(OP_RUN, '0);
		// empty run, then disjoint lines (removal/addition tie-break)
		send_request(OP_RUN, '0);
		send_request(OP_APPEND_A, 32'hAAAA_5555);
		send_request(OP_APPEND_B, 32'h5555_AAAA);
		send_request(OP_APPEND_A, 32'h1);
		send_request(OP_RUN, '0);
		drain();

		// Fill the first sequence past capacity so the overflow flag rises
		for (k = 0; k < LINES + 2; k++) send_request(OP_APPEND_A, k % 3);
		send_request(OP_APPEND_B, 32'd1);
		send_request(OP_RUN, '0);
		drain();

		// Sweep the mask through every setting, extremes included
		for (n = 0; n < 4; n++) begin
			write_mask(n[1:0]);
			repeat (4) random_diff(6);
			drain();
		end

		// All lines masked away except none kept: no edits expected
		write_mask(2'd0);
		send_request(OP_APPEND_A, 32'd7);
		send_request(OP_APPEND_B, 32'd8);
		send_request(OP_RUN, '0);
		drain();
		write_mask(2'd3);

		// Back pressure: stall the output while requests keep coming
		holdoff_cycles = 300;
		burst_mode = 1;
		repeat (3) random_diff(8);
		burst_mode = 0;
		drain();

		// Random bulk, with one diff that may reach full size or beyond
		for (k = 0; k < 12; k++) begin
			if (k % 10 == 9) random_diff(LINES + 1);
			else random_diff(5);
			if (k % 8 == 7) begin
				drain();
				write_mask($urandom_range(0, 3));
			end
		end
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule
